>>> rtl/aqls_pkg.sv
package aqls_pkg;

    localparam int MAX_COLUMNS = 1024;
    localparam int ADDR_W      = $clog2(MAX_COLUMNS);
    localparam int CNT_W       = $clog2(MAX_COLUMNS + 1);
    localparam int LIMITS      = 5;
    localparam int LIMIT_W     = 3;
    localparam int DEN_W       = 16;
    localparam int QLEN_W      = 11;
    localparam int FLAG_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int PROD_W      = CNT_W + DEN_W;

    localparam int FLAG_MISMATCH = 0;
    localparam int FLAG_TARGET   = 1;

    localparam logic [LIMIT_W-1:0] FIRST_LIMIT = '0;
    localparam logic [LIMIT_W-1:0] LAST_LIMIT  = LIMIT_W'(LIMITS - 1);

    typedef logic [LIMITS-1:0][DEN_W-1:0] t_dens;

    localparam t_dens DEN_RESET = {16'd50000, 16'd100, 16'd50, 16'd10, 16'd5};

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [FLAG_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

endpackage

>>> rtl/aqls_in_if.sv
interface aqls_in_if;
    logic valid;
    logic ready;
    logic column_matches;
    logic target_is_gap;
    logic last_column;

    modport source (
        output valid, column_matches, target_is_gap, last_column,
        input  ready
    );
    modport sink (
        input  valid, column_matches, target_is_gap, last_column,
        output ready
    );
endinterface

>>> rtl/aqls_out_if.sv
interface aqls_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  limit_index;
    logic [10:0] qualified_length;
    logic        capacity_overflow;
    logic        last_result;

    modport source (
        output valid, limit_index, qualified_length, capacity_overflow, last_result,
        input  ready
    );
    modport sink (
        input  valid, limit_index, qualified_length, capacity_overflow, last_result,
        output ready
    );
endinterface

>>> rtl/aqls_ram.sv
module aqls_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/aqls_cfg.sv
module aqls_cfg import aqls_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEN_W-1:0]     i_cfg_data,
    output t_dens                o_dens
);
    t_dens r_dens;
    t_dens n_dens;

    always_comb begin
        n_dens = r_dens;
        for (int k = 0; k < LIMITS; k++) begin
            if (i_cfg_we && i_cfg_index == CFG_IDX_W'(k)) begin
                n_dens[k] = i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dens <= DEN_RESET;
        end else begin
            r_dens <= n_dens;
        end
    end

    assign o_dens = r_dens;
endmodule

>>> rtl/aqls_ctrl.sv
module aqls_ctrl import aqls_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    aqls_in_if.sink           i_col,
    aqls_out_if.source        o_res,
    input  t_dens             i_dens,
    output t_ram_req          o_ram,
    input  logic [FLAG_W-1:0] i_rdata
);
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [CNT_W-1:0]   r_mism, n_mism;
    logic               r_ovf, n_ovf;
    logic [ADDR_W-1:0]  r_pos, n_pos;
    logic [LIMIT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_err, n_err;
    logic [CNT_W-1:0]   r_prev_len, n_prev_len;
    logic [CNT_W-1:0]   r_prev_err, n_prev_err;
    logic [CNT_W-1:0]   r_result, n_result;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic               r_out_valid, n_out_valid;
    logic [LIMIT_W-1:0] r_out_k, n_out_k;
    logic [QLEN_W-1:0]  r_out_len, n_out_len;
    logic               r_out_ovf, n_out_ovf;
    logic               r_out_last, n_out_last;

    logic              w_accept;
    logic              w_room;
    logic              w_slot_free;
    logic [DEN_W-1:0]  w_den;
    logic [CNT_W-1:0]  w_count_inc;

    assign i_col.ready = (r_state == S_LOAD);
    assign w_accept    = i_col.valid && i_col.ready;
    assign w_room      = r_count < CNT_W'(MAX_COLUMNS);
    assign w_slot_free = !r_out_valid || o_res.ready;
    assign w_den       = i_dens[r_k];
    assign w_count_inc = r_count + CNT_W'(1);

    assign o_ram.we    = w_accept && w_room;
    assign o_ram.waddr = ADDR_W'(r_count);
    assign o_ram.wdata = {!i_col.target_is_gap, !i_col.column_matches};
    assign o_ram.raddr = r_pos;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_total     = r_total;
        n_mism      = r_mism;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_k         = r_k;
        n_len       = r_len;
        n_err       = r_err;
        n_prev_len  = r_prev_len;
        n_prev_err  = r_prev_err;
        n_result    = r_result;
        n_prod      = r_prod;
        n_out_valid = r_out_valid && !o_res.ready;
        n_out_k     = r_out_k;
        n_out_len   = r_out_len;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;

        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    if (w_room) begin
                        n_count = w_count_inc;
                        n_total = r_total + CNT_W'(!i_col.target_is_gap);
                        n_mism  = r_mism + CNT_W'(!i_col.column_matches);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_col.last_column) begin
                        n_pos      = ADDR_W'(n_count - CNT_W'(1));
                        n_k        = FIRST_LIMIT;
                        n_prev_len = '0;
                        n_prev_err = '0;
                        n_state    = S_START;
                    end
                end
            end
            S_START: begin
                if (r_k == FIRST_LIMIT) begin
                    n_len = r_total;
                    n_err = r_mism;
                end else begin
                    n_len = r_prev_len;
                    n_err = r_prev_err;
                end
                n_state = S_TEST;
            end
            S_TEST: begin
                if (r_len == '0 || r_pos == '0) begin
                    n_result = '0;
                    n_state  = S_EMIT;
                end else begin
                    n_prod  = PROD_W'(r_err) * PROD_W'(w_den);
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_prod <= PROD_W'(r_len)) begin
                    n_result   = r_len;
                    n_prev_len = r_len;
                    n_prev_err = r_err;
                    n_state    = S_EMIT;
                end else begin
                    if (i_rdata[FLAG_MISMATCH] && r_err != '0) begin
                        n_err = r_err - CNT_W'(1);
                    end
                    if (i_rdata[FLAG_TARGET]) begin
                        n_len = r_len - CNT_W'(1);
                    end
                    n_pos   = r_pos - ADDR_W'(1);
                    n_state = S_TEST;
                end
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_k     = r_k;
                    n_out_len   = QLEN_W'(r_result);
                    n_out_ovf   = r_ovf;
                    n_out_last  = (r_k == LAST_LIMIT);
                    if (r_k == LAST_LIMIT) begin
                        n_count = '0;
                        n_total = '0;
                        n_mism  = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + LIMIT_W'(1);
                        n_state = S_START;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_mism      <= '0;
            r_ovf       <= 1'b0;
            r_k         <= FIRST_LIMIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_total     <= n_total;
            r_mism      <= n_mism;
            r_ovf       <= n_ovf;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_len      <= n_len;
        r_err      <= n_err;
        r_prev_len <= n_prev_len;
        r_prev_err <= n_prev_err;
        r_result   <= n_result;
        r_prod     <= n_prod;
        r_out_k    <= n_out_k;
        r_out_len  <= n_out_len;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.limit_index       = r_out_k;
    assign o_res.qualified_length  = r_out_len;
    assign o_res.capacity_overflow = r_out_ovf;
    assign o_res.last_result       = r_out_last;
endmodule

>>> rtl/alignment_quality_length_scorer_core.sv
// One column transaction is taken per cycle while the block is loading.
// After the last column, each limit passes through a start state, a test state,
// a check and another test for each trimmed column, and the emit state into the
// output register; the backward scan through the column memory sets how long a
// limit takes, and a stalled result sink holds the emit state. Reset is
// synchronous and active low: it clears the counts and the controller and
// restores the default denominators.
module alignment_quality_length_scorer_core import aqls_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEN_W-1:0]     i_cfg_data,
    aqls_in_if.sink              i_col,
    aqls_out_if.source           o_res
);
    t_dens             w_dens;
    t_ram_req          w_ram;
    logic [FLAG_W-1:0] w_rdata;

    aqls_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_dens      (w_dens)
    );

    aqls_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_COLUMNS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram.we),
        .i_waddr (w_ram.waddr),
        .i_wdata (w_ram.wdata),
        .i_raddr (w_ram.raddr),
        .o_rdata (w_rdata)
    );

    aqls_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_col   (i_col),
        .o_res   (o_res),
        .i_dens  (w_dens),
        .o_ram   (w_ram),
        .i_rdata (w_rdata)
    );
endmodule

>>> rtl/aqls_checker.sv
module aqls_checker import aqls_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_res_valid,
    input logic              i_res_ready,
    input logic [2:0]        i_res_limit_index,
    input logic [QLEN_W-1:0] i_res_qualified_length,
    input logic              i_res_capacity_overflow,
    input logic              i_res_last_result
);
    logic [2:0] r_exp_k;
    logic       w_res_xfer;

    assign w_res_xfer = i_res_valid && i_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_k <= '0;
        end else if (w_res_xfer) begin
            r_exp_k <= i_res_last_result ? 3'd0 : r_exp_k + 3'd1;
        end
    end

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid
            && $stable(i_res_limit_index) && $stable(i_res_qualified_length)
            && $stable(i_res_capacity_overflow) && $stable(i_res_last_result))
        else $error("result payload changed while stalled");

    // Results of one alignment come out in limit order.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_xfer |-> i_res_limit_index == r_exp_k)
        else $error("result limit out of order");

    // The last flag marks exactly the result of the final limit.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_res_last_result == (i_res_limit_index == LAST_LIMIT))
        else $error("last flag does not match the final limit");

    // A qualified length never exceeds the column capacity.
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> 32'(i_res_qualified_length) <= 32'(MAX_COLUMNS))
        else $error("qualified length above capacity");
endmodule

bind alignment_quality_length_scorer_core aqls_checker u_aqls_checker (
    .i_clk                   (i_clk),
    .i_rst_n                 (i_rst_n),
    .i_res_valid             (o_res.valid),
    .i_res_ready             (o_res.ready),
    .i_res_limit_index       (o_res.limit_index),
    .i_res_qualified_length  (o_res.qualified_length),
    .i_res_capacity_overflow (o_res.capacity_overflow),
    .i_res_last_result       (o_res.last_result)
);
